/* hw/rtl/echo_capture_distance_alarm_unit_assert.svh */
// Assertion macros shared by the echo capture distance alarm RTL.
`ifndef ECHO_CAPTURE_DISTANCE_ALARM_UNIT_ASSERT_SVH
`define ECHO_CAPTURE_DISTANCE_ALARM_UNIT_ASSERT_SVH

// Clocked check, masked while in reset.
`define ECDA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ECDA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/ecda_pkg.sv */
// Package: widths, constants and the queue word type of the distance alarm.
`default_nettype none

package ecda_pkg;

    localparam int COUNT_BITS = 16;
    localparam int FRAC_BITS  = 16;

    localparam int CAP_W   = COUNT_BITS;
    localparam int WIDTH_W = COUNT_BITS + 1;
    localparam int TICK_W  = COUNT_BITS + 1;
    localparam int DIST_W  = 26;
    localparam int PER_W   = 13;

    // floor(x/3) for x < 2^(COUNT_BITS+3) as (x * DIV3_MULT) >> DIV3_SHIFT
    localparam int DIV3_SHIFT = COUNT_BITS + 3;
    localparam int DIV3_W     = COUNT_BITS + 2;
    localparam longint unsigned DIV3_MULT = ((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3;

    // inches per tick scale, 0.0343/2.54 with FRAC_BITS fraction bits
    localparam int K_W = FRAC_BITS - 6;
    localparam longint unsigned INCH_SCALE =
        ((64'd343 << FRAC_BITS) + 64'd12700) / 64'd25400;

    localparam int NEAR_INCHES = 12;
    localparam int MID_INCHES  = 24;
    localparam int TONE_BASE   = 1000;
    localparam int TONE_SLOPE  = 208;
    localparam int MODULUS_RESET = 44999;

    localparam logic [DIST_W-1:0] NEAR_LIM =
        DIST_W'(64'(NEAR_INCHES) << FRAC_BITS);
    localparam logic [DIST_W-1:0] MID_LIM =
        DIST_W'(64'(MID_INCHES) << FRAC_BITS);

    localparam int QUEUE_DEPTH = 2;

    // one word from front to back
    typedef struct packed {
        logic               off;
        logic [WIDTH_W-1:0] width;
    } ecda_word_t;

endpackage

`default_nettype wire

/* hw/rtl/echo_capture_distance_alarm_unit.sv */
// Top level of the echo capture distance alarm: front, queue and back.
//
//  channel   dir   handshake            word
//  -------   ---   ------------------   ------------------------------------------
//  cfg       in    cfg_we               cfg_wdata -> timer_modulus
//  in        in    in_valid/in_ready    capture_value, measure_enable
//  out       out   out_valid/out_ready  pulse_width, distance_inches_q16, red_led,
//                                       blue_led, buzzer_on, buzzer_period
//
// One capture word accepted per cycle while in_ready is high; out_valid rises after
// the closing capture's queue write and the ticks, distance and tone stages.
// The first capture of an enabled pair only updates the pairing registers.
// A two-word queue separates front and back; in_ready drops only when it is full.
// The back pipeline holds in place while out_ready is low.
// Reset (rst_n low, async) clears the pairing state, queue and pipeline valids and
// loads timer_modulus with 44999.
`default_nettype none

module echo_capture_distance_alarm_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [15:0]                 cfg_wdata,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [ecda_pkg::CAP_W-1:0]  capture_value,
    input  wire logic                        measure_enable,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [ecda_pkg::WIDTH_W-1:0]     pulse_width,
    output logic [ecda_pkg::DIST_W-1:0]      distance_inches_q16,
    output logic                             red_led,
    output logic                             blue_led,
    output logic                             buzzer_on,
    output logic [ecda_pkg::PER_W-1:0]       buzzer_period
);
    import ecda_pkg::*;

    logic       q_full, q_valid, push, pop;
    ecda_word_t push_word, q_word;

    // pairing and width
    ecda_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .capture_value  (capture_value),
        .measure_enable (measure_enable),
        .q_full         (q_full),
        .push           (push),
        .push_word      (push_word)
    );

    // decoupling queue
    ecda_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .full      (q_full),
        .q_valid   (q_valid),
        .pop       (pop),
        .q_word    (q_word)
    );

    // distance, zone and tone
    ecda_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .q_valid             (q_valid),
        .q_word              (q_word),
        .pop                 (pop),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .pulse_width         (pulse_width),
        .distance_inches_q16 (distance_inches_q16),
        .red_led             (red_led),
        .blue_led            (blue_led),
        .buzzer_on           (buzzer_on),
        .buzzer_period       (buzzer_period)
    );

endmodule

`default_nettype wire

/* hw/rtl/ecda_front.sv */
// Front: holds the timer modulus, pairs captures and forms the pulse width.
`default_nettype none

module ecda_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [15:0]               cfg_wdata,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [ecda_pkg::CAP_W-1:0] capture_value,
    input  wire logic                      measure_enable,
    input  wire logic                      q_full,
    output logic                           push,
    output ecda_pkg::ecda_word_t           push_word
);
    import ecda_pkg::*;

    logic [15:0]      modulus_reg;
    logic [CAP_W-1:0] first_reg, first_next;
    logic             phase_reg, phase_next;
    logic             accept;
    logic [WIDTH_W-1:0] width;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (capture_value > first_reg)
        begin
            width = WIDTH_W'(capture_value) - WIDTH_W'(first_reg);
        end
        else
        begin
            width = WIDTH_W'(capture_value) - WIDTH_W'(first_reg)
                  + WIDTH_W'(modulus_reg) + WIDTH_W'(1);
        end
    end

    always_comb
    begin
        first_next = first_reg;
        phase_next = phase_reg;
        if (accept && measure_enable)
        begin
            phase_next = !phase_reg;
            if (!phase_reg)
            begin
                first_next = capture_value;
            end
        end
    end

    // disabled captures answer at once; enabled ones only on the closing edge
    assign push            = accept && (!measure_enable || phase_reg);
    assign push_word.off   = !measure_enable;
    assign push_word.width = measure_enable ? width : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= 16'(MODULUS_RESET);
            first_reg   <= '0;
            phase_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                modulus_reg <= cfg_wdata;
            end
            first_reg <= first_next;
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ecda_queue.sv */
// Queue: two-entry FIFO of words between front and back.
`default_nettype none
`include "echo_capture_distance_alarm_unit_assert.svh"

module ecda_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  ecda_pkg::ecda_word_t      push_word,
    output logic                      full,
    output logic                      q_valid,
    input  wire logic                 pop,
    output ecda_pkg::ecda_word_t      q_word
);
    import ecda_pkg::*;

    ecda_word_t mem [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'(QUEUE_DEPTH));
    assign q_valid = (count_reg != 2'd0);
    assign q_word  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ECDA_ASSERT_ALWAYS(a_q_count_max, count_reg <= 2'(QUEUE_DEPTH), "queue over depth")
    `ECDA_ASSERT(a_q_no_push_full, push |-> !full, "push into full queue")
    `ECDA_ASSERT(a_q_no_pop_empty, pop |-> q_valid, "pop from empty queue")

endmodule

`default_nettype wire

/* hw/rtl/ecda_back.sv */
// Back: three-stage pipeline from pulse width to distance, zone and tone.
`default_nettype none
`include "echo_capture_distance_alarm_unit_assert.svh"

module ecda_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        q_valid,
    input  ecda_pkg::ecda_word_t             q_word,
    output logic                             pop,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [ecda_pkg::WIDTH_W-1:0]     pulse_width,
    output logic [ecda_pkg::DIST_W-1:0]      distance_inches_q16,
    output logic                             red_led,
    output logic                             blue_led,
    output logic                             buzzer_on,
    output logic [ecda_pkg::PER_W-1:0]       buzzer_period
);
    import ecda_pkg::*;

    localparam int PROD_W = TICK_W + K_W;

    // stage 1: ticks = width*2/3
    logic               s1_v_reg;
    logic               s1_off_reg;
    logic [WIDTH_W-1:0] s1_width_reg;
    logic [TICK_W-1:0]  s1_ticks_reg;
    // stage 2: saturated distance
    logic               s2_v_reg;
    logic               s2_off_reg;
    logic [WIDTH_W-1:0] s2_width_reg;
    logic [DIST_W-1:0]  s2_dist_reg;
    // stage 3: output register
    logic               out_v_reg;

    logic en_out, en2, en1;
    logic [DIV3_W-1:0]          twice_w;
    logic [2*DIV3_W-1:0]        div3_prod;
    logic [PROD_W-1:0]          dist_prod;
    logic                       dist_sat;
    logic [DIST_W-1:0]          dist_val;
    logic [DIST_W+7:0]          tone_prod;
    logic                       near, mid;
    logic [PER_W-1:0]           period;

    assign en_out = !out_v_reg || out_ready;
    assign en2    = !s2_v_reg  || en_out;
    assign en1    = !s1_v_reg  || en2;
    assign pop    = q_valid && en1;
    assign out_valid = out_v_reg;

    always_comb
    begin
        twice_w   = {q_word.width, 1'b0};
        div3_prod = twice_w * DIV3_W'(DIV3_MULT);
        dist_prod = s1_ticks_reg * K_W'(INCH_SCALE);
        dist_sat  = |(dist_prod >> DIST_W);
        dist_val  = dist_sat ? '1 : DIST_W'(dist_prod);
        tone_prod = s2_dist_reg * 8'(TONE_SLOPE);
        period    = PER_W'(tone_prod >> FRAC_BITS) + PER_W'(TONE_BASE);
        near      = !s2_off_reg && (s2_dist_reg < NEAR_LIM);
        mid       = !s2_off_reg && !near && (s2_dist_reg < MID_LIM);
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en1 && q_valid)
        begin
            s1_off_reg   <= q_word.off;
            s1_width_reg <= q_word.width;
            s1_ticks_reg <= TICK_W'(div3_prod >> DIV3_SHIFT);
        end
        if (en2 && s1_v_reg)
        begin
            s2_off_reg   <= s1_off_reg;
            s2_width_reg <= s1_width_reg;
            s2_dist_reg  <= s1_off_reg ? '0 : dist_val;
        end
        if (en_out && s2_v_reg)
        begin
            pulse_width         <= s2_width_reg;
            distance_inches_q16 <= s2_dist_reg;
            red_led             <= near;
            blue_led            <= mid;
            buzzer_on           <= near || mid;
            buzzer_period       <= (near || mid) ? period : '0;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_v_reg <= q_valid;
            end
            if (en2)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (en_out)
            begin
                out_v_reg <= s2_v_reg;
            end
        end
    end

    `ECDA_ASSERT(a_b_zone_excl, out_valid |-> !(red_led && blue_led), "both zone LEDs lit")
    `ECDA_ASSERT(a_b_buzz_zone, out_valid |-> (buzzer_on == (red_led || blue_led)),
        "buzzer disagrees with zone")
    `ECDA_ASSERT(a_b_red_near, (out_valid && red_led) |-> (distance_inches_q16 < NEAR_LIM),
        "red LED outside near zone")
    `ECDA_ASSERT(a_b_quiet, (out_valid && !buzzer_on) |-> (buzzer_period == '0),
        "tone period set with buzzer off")

endmodule

`default_nettype wire

/* sim/tb_echo_capture_distance_alarm_unit.sv */
// Self-checking testbench for the echo capture distance alarm unit.
`timescale 1ns / 100ps

module tb_echo_capture_distance_alarm_unit;

    import ecda_pkg::*;

    // Inches per timer tick, 0.0343 / 2.54, rounded to 16 fraction bits.
    localparam longint unsigned TICK_INCH_K = ((64'd343 << 16) + 64'd12700) / 64'd25400;
    localparam longint unsigned DIST_SAT    = (64'd1 << DIST_W) - 1;
    // Cycles to let the back pipeline settle before a register write or the end.
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int MAX_PRINTS    = 40;

    // One result word as it leaves the block.
    typedef struct packed {
        logic [WIDTH_W-1:0] width;
        logic [DIST_W-1:0]  distance;
        logic               red;
        logic               blue;
        logic               buzz;
        logic [PER_W-1:0]   period;
    } alarm_word_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b1;
    logic                cfg_we = 1'b0;
    logic [15:0]         cfg_wdata = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [CAP_W-1:0]    capture_value = '0;
    logic                measure_enable = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [WIDTH_W-1:0]  pulse_width;
    logic [DIST_W-1:0]   distance_inches_q16;
    logic                red_led;
    logic                blue_led;
    logic                buzzer_on;
    logic [PER_W-1:0]    buzzer_period;

    // Shadow of the block's state and its one register.
    logic [15:0]         tick_modulus = 16'(MODULUS_RESET);
    logic [CAP_W-1:0]    first_count = '0;
    logic                pair_open = 1'b0;

    alarm_word_t         expected_alarms[$];
    int                  error_count = 0;

    // Traffic shaping, set by each test.
    int                  sender_idle_pct = 0;
    int                  recv_stall_pct = 0;
    int                  hold_cycles = 0;

    echo_capture_distance_alarm_unit dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_wdata           (cfg_wdata),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .capture_value       (capture_value),
        .measure_enable      (measure_enable),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .pulse_width         (pulse_width),
        .distance_inches_q16 (distance_inches_q16),
        .red_led             (red_led),
        .blue_led            (blue_led),
        .buzzer_on           (buzzer_on),
        .buzzer_period       (buzzer_period)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    //--------------------------------------------------------------------------
    // Alarm predictor: pairs enabled captures, then width -> inches -> zone.
    //--------------------------------------------------------------------------
    function automatic void predict_alarm(logic [CAP_W-1:0] cap, logic en);
        alarm_word_t     w;
        longint unsigned width;
        longint unsigned ticks;
        longint unsigned dist_q;
        longint unsigned tone;
        w = '0;
        // Disabled: all-off word, pairing state untouched.
        if (!en)
        begin
            expected_alarms.push_back(w);
            return;
        end
        // Opening edge of a pair only latches the count.
        if (!pair_open)
        begin
            first_count = cap;
            pair_open   = 1'b1;
            return;
        end
        pair_open = 1'b0;
        // Equal captures fall into the wrap branch: a full modulus + 1.
        if (cap > first_count)
            width = 64'(cap) - 64'(first_count);
        else
            width = (64'(cap) - 64'(first_count) + 64'(tick_modulus) + 1)
                    & ((64'd1 << WIDTH_W) - 1);
        ticks  = (width * 2) / 3;
        dist_q = ticks * TICK_INCH_K;
        if (dist_q > DIST_SAT)
            dist_q = DIST_SAT;
        w.width    = WIDTH_W'(width);
        w.distance = DIST_W'(dist_q);
        // Far zone keeps width and distance but silences LEDs and buzzer.
        if (dist_q < (64'(MID_INCHES) << FRAC_BITS))
        begin
            tone     = (dist_q * TONE_SLOPE) >> FRAC_BITS;
            w.period = PER_W'(TONE_BASE + tone);
            w.buzz   = 1'b1;
            w.red    = (dist_q < (64'(NEAR_INCHES) << FRAC_BITS));
            w.blue   = !w.red;
        end
        expected_alarms.push_back(w);
    endfunction

    task automatic flag_error(input string msg);
        if (error_count < MAX_PRINTS)
            $display("[%0t] ERROR: %s", $realtime, msg);
        error_count++;
    endtask

    //--------------------------------------------------------------------------
    // Result checker: every accepted word against the oldest expectation.
    //--------------------------------------------------------------------------
    always @(posedge clk)
    begin
        alarm_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_alarms.size() == 0)
                flag_error($sformatf("unexpected word width=%0d dist=%0d",
                                     pulse_width, distance_inches_q16));
            else
            begin
                want = expected_alarms.pop_front();
                if (pulse_width !== want.width)
                    flag_error($sformatf("pulse_width %0d, want %0d", pulse_width, want.width));
                if (distance_inches_q16 !== want.distance)
                    flag_error($sformatf("distance_inches_q16 %0d, want %0d",
                                         distance_inches_q16, want.distance));
                if (red_led !== want.red)
                    flag_error($sformatf("red_led %b, want %b", red_led, want.red));
                if (blue_led !== want.blue)
                    flag_error($sformatf("blue_led %b, want %b", blue_led, want.blue));
                if (buzzer_on !== want.buzz)
                    flag_error($sformatf("buzzer_on %b, want %b", buzzer_on, want.buzz));
                if (buzzer_period !== want.period)
                    flag_error($sformatf("buzzer_period %0d, want %0d",
                                         buzzer_period, want.period));
            end
        end
    end

    //--------------------------------------------------------------------------
    // Receiver: random stalls, plus a forced hold-off counted down here.
    //--------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_cycles != 0)
            hold_cycles <= hold_cycles - 1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || hold_cycles != 0)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    //--------------------------------------------------------------------------
    // Sender: optional idle gap, then hold the word until accepted.
    // in_valid stays high afterwards so back-to-back words never toggle it.
    //--------------------------------------------------------------------------
    task automatic send_capture(input logic [CAP_W-1:0] cap, input logic en);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        capture_value  <= cap;
        measure_enable <= en;
        do
            @(posedge clk);
        while (!in_ready);
        predict_alarm(cap, en);
    endtask

    task automatic send_pair(input logic [CAP_W-1:0] first, input logic [CAP_W-1:0] second);
        send_capture(first, 1'b1);
        send_capture(second, 1'b1);
    endtask

    // Stop sending, wait for every expected word, then let the pipe settle.
    task automatic settle_block();
        in_valid <= 1'b0;
        while (expected_alarms.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_modulus(input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we       <= 1'b0;
        tick_modulus = value;
    endtask

    //--------------------------------------------------------------------------
    // Tests
    //--------------------------------------------------------------------------

    // Zones, boundaries, wrap, equal captures, disabled and saturation at reset modulus.
    task automatic test_directed();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        send_pair(16'd100, 16'd100);          // equal captures
        send_pair(16'd0, 16'hFFFF);           // max straight width, beyond modulus
        send_pair(16'hFFFF, 16'd0);           // negative wrap
        send_pair(16'd1000, 16'd1500);        // near
        send_pair(16'd1000, 16'd3000);        // middle
        send_pair(16'd44000, 16'd100);        // wrap through modulus
        send_capture(16'd10, 1'b1);           // disabled word inside an open pair
        send_capture(16'd5, 1'b0);
        send_capture(16'd20, 1'b1);
        send_pair(16'd0, 16'd1333);           // last near width
        send_pair(16'd0, 16'd1334);           // first middle width
        send_pair(16'd0, 16'd2666);           // last middle width
        send_pair(16'd0, 16'd2667);           // first far width
        send_pair(16'd50000, 16'd4000);       // distance saturates
        settle_block();
    endtask

    // Zero modulus: wrap term of one.
    task automatic test_zero_modulus();
        set_modulus(16'd0);
        send_pair(16'd5, 16'd5);
        send_pair(16'd2, 16'd0);
        send_pair(16'd0, 16'd3);
        settle_block();
    endtask

    // Receiver holds off while the sender keeps offering, so in_ready drops.
    task automatic test_backpressure_fill();
        int i;
        set_modulus(16'd44999);
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_cycles     <= 400;
        for (i = 0; i < 20; i++)
            send_pair(CAP_W'($urandom_range(40000)), CAP_W'($urandom_range(44999, 40001)));
        settle_block();
    endtask

    // Mostly well-formed pairs with random span, plus disabled words,
    // lone edges and captures at or past the modulus.
    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct);
        int              sent;
        int              pick;
        longint unsigned first;
        longint unsigned span;
        longint unsigned second;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 72)
            begin
                // Close a dangling edge first so the pair lines up.
                if (pair_open)
                begin
                    send_capture(CAP_W'($urandom_range(tick_modulus)), 1'b1);
                    sent++;
                end
                case ($urandom_range(9))
                    0:       span = 0;
                    8:       span = $urandom_range(65535, 1);
                    9:       span = $urandom_range(2680, 1320);
                    default: span = $urandom_range(2800, 1);
                endcase
                first  = $urandom_range(tick_modulus);
                second = (first + span) % (64'(tick_modulus) + 1);
                send_capture(CAP_W'(first), 1'b1);
                if ($urandom_range(9) == 0)
                begin
                    send_capture(CAP_W'($urandom), 1'b0);
                    sent++;
                end
                send_capture(CAP_W'(second), 1'b1);
                sent += 2;
            end
            else if (pick < 84)
            begin
                send_capture(CAP_W'($urandom), 1'b0);
                sent++;
            end
            else if (pick < 92)
            begin
                send_capture(CAP_W'($urandom), 1'b1);
                sent++;
            end
            else
            begin
                // Capture at or past the modulus.
                send_capture(CAP_W'($urandom_range(65535, tick_modulus)), 1'b1);
                sent++;
            end
        end
        settle_block();
    endtask

    //--------------------------------------------------------------------------
    // Sequence
    //--------------------------------------------------------------------------
    initial
    begin
        int waited;
        rst_n <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_zero_modulus();
        test_backpressure_fill();

        set_modulus(16'd44999);
        test_random_traffic(150, 0, 0);
        set_modulus(16'd65535);
        test_random_traffic(150, 59, 0);
        set_modulus(16'd1);
        test_random_traffic(60, 0, 59);
        set_modulus(16'($urandom_range(65535, 3000)));
        test_random_traffic(150, 0, 59);
        set_modulus(16'd2000);
        test_random_traffic(150, 28, 28);

        // Final drain with a bound; anything left over is a failure.
        in_valid <= 1'b0;
        waited = 0;
        while (expected_alarms.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_alarms.size() != 0)
            flag_error($sformatf("%0d expected words never arrived", expected_alarms.size()));
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb_echo_capture_distance_alarm_unit OK");
        else
            $display("tb_echo_capture_distance_alarm_unit NOT OK");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #4_000_000;
        $display("tb_echo_capture_distance_alarm_unit NOT OK");
        $finish;
    end

endmodule
